// File: design/wtdp_pkg.sv
package wtdp_pkg;

    // Goal scaling: feet to inches
    localparam logic signed [8:0] INCHES_PER_UNIT = 9'sd12;

    // Reset values of the configuration registers
    localparam logic [9:0] TURN_SPEED_RST  = 10'd400;
    localparam logic [9:0] TURN_ACCEL_RST  = 10'd800;
    localparam logic [9:0] DRIVE_SPEED_RST = 10'd200;
    localparam logic [9:0] DRIVE_ACCEL_RST = 10'd400;
    localparam logic [7:0] SPRA_RST        = 8'd130;

    localparam logic [10:0] STEP_MAX = 11'd2047;

    // floor(v/27) for v < 2^16 is (v * RECIP_27) >> 21
    localparam logic [16:0] RECIP_27 = 17'd77673;
    // floor(v/90) for v < 2^16 is (v * RECIP_90) >> 22
    localparam logic [15:0] RECIP_90 = 16'd46604;
    localparam logic [15:0] DIST_SCALE = 16'd62500;

    localparam logic [22:0] DEG45_Q16  = 23'd2949120;
    localparam logic [22:0] DEG90_Q16  = 23'd5898240;
    localparam logic [23:0] DEG180_Q16 = 24'd11796480;
    localparam logic [22:0] A_MAX_Q16  = 23'd5898239;

    localparam int CORDIC_ITERS = 16;

    localparam logic [22:0] ATAN_Q16 [CORDIC_ITERS] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115
    };

    typedef enum logic [2:0] {
        CFG_TURN_SPEED  = 3'd0,
        CFG_TURN_ACCEL  = 3'd1,
        CFG_DRIVE_SPEED = 3'd2,
        CFG_DRIVE_ACCEL = 3'd3,
        CFG_SPRA        = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        MOVE_SPIN_LEFT  = 2'd0,
        MOVE_SPIN_RIGHT = 2'd1,
        MOVE_FORWARD    = 2'd2
    } move_kind_t;

    typedef enum logic {
        SEL_SPIN = 1'b0,
        SEL_FWD  = 1'b1
    } out_sel_t;

    typedef struct packed {
        logic     load;    // capture goal, form deltas
        logic     square;  // squares, CORDIC init
        logic     setup;   // scaled sum of squares, root init
        logic     step;    // one CORDIC and one root iteration
        logic     post1;   // bearing, distance product
        logic     post2;   // heading change, spin product, distance steps, pose commit
        logic     post3;   // spin steps
        logic [3:0] iter;
        out_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic has_spin;
        logic dbl;
    } status_t;

endpackage

// File: design/wtdp_ctrl.sv
module wtdp_ctrl
    import wtdp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SUM, S_ITER, S_POST1, S_POST2, S_POST3,
        S_OUT_SPIN1, S_OUT_SPIN2, S_OUT_FWD
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] iter_reg, iter_next;
    logic       valid_reg, valid_next;
    out_sel_t   sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_SQ;
                end
            end
            S_SQ:  state_next = S_SUM;
            S_SUM: begin
                state_next = S_ITER;
                iter_next  = 4'd0;
            end
            S_ITER: begin
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'(CORDIC_ITERS - 1)) begin
                    state_next = S_POST1;
                end
            end
            S_POST1: state_next = S_POST2;
            S_POST2: state_next = S_POST3;
            S_POST3: begin
                valid_next = 1'b1;
                if (status.has_spin) begin
                    state_next = S_OUT_SPIN1;
                    sel_next   = SEL_SPIN;
                end else begin
                    state_next = S_OUT_FWD;
                    sel_next   = SEL_FWD;
                end
            end
            S_OUT_SPIN1: begin
                if (out_ready) begin
                    if (status.dbl) begin
                        state_next = S_OUT_SPIN2;
                    end else begin
                        state_next = S_OUT_FWD;
                        sel_next   = SEL_FWD;
                    end
                end
            end
            S_OUT_SPIN2: begin
                if (out_ready) begin
                    state_next = S_OUT_FWD;
                    sel_next   = SEL_FWD;
                end
            end
            S_OUT_FWD: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                    valid_next = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= 4'd0;
            valid_reg <= 1'b0;
            sel_reg   <= SEL_SPIN;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

    always_comb begin
        cmd        = '0;
        cmd.load   = in_valid && (state_reg == S_IDLE);
        cmd.square = (state_reg == S_SQ);
        cmd.setup  = (state_reg == S_SUM);
        cmd.step   = (state_reg == S_ITER);
        cmd.post1  = (state_reg == S_POST1);
        cmd.post2  = (state_reg == S_POST2);
        cmd.post3  = (state_reg == S_POST3);
        cmd.iter   = iter_reg;
        cmd.sel    = sel_reg;
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !out_valid)
        else $error("input ready while a result is pending");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second item without finishing");
    a_fwd_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_ready && sel_reg == SEL_FWD) |=> (in_ready && !out_valid))
        else $error("forward move did not end the run");
    a_spin_needs_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && sel_reg == SEL_SPIN) |-> status.has_spin)
        else $error("spin emitted without heading change");
`endif

endmodule

// File: design/wtdp_dp.sv
module wtdp_dp
    import wtdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic [3:0]  goal_x,
    input  logic [3:0]  goal_y,
    input  cmd_t        cmd,
    output status_t     status,
    output logic [1:0]  move_kind,
    output logic [10:0] step_count,
    output logic [9:0]  move_speed,
    output logic [9:0]  move_accel,
    output logic        last_move
);

    // configuration
    logic [9:0] turn_speed_reg, turn_accel_reg, drive_speed_reg, drive_accel_reg;
    logic [7:0] spra_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_speed_reg  <= TURN_SPEED_RST;
            turn_accel_reg  <= TURN_ACCEL_RST;
            drive_speed_reg <= DRIVE_SPEED_RST;
            drive_accel_reg <= DRIVE_ACCEL_RST;
            spra_reg        <= SPRA_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TURN_SPEED:  turn_speed_reg  <= cfg_data;
                CFG_TURN_ACCEL:  turn_accel_reg  <= cfg_data;
                CFG_DRIVE_SPEED: drive_speed_reg <= cfg_data;
                CFG_DRIVE_ACCEL: drive_accel_reg <= cfg_data;
                CFG_SPRA:        spra_reg        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // goal scaling and deltas
    logic signed [8:0] gx_prod, gy_prod;
    logic signed [7:0] gx, gy;
    logic signed [8:0] dx_w, dy_w;

    assign gx_prod = $signed({{5{goal_x[3]}}, goal_x}) * INCHES_PER_UNIT;
    assign gy_prod = $signed({{5{goal_y[3]}}, goal_y}) * INCHES_PER_UNIT;
    assign gx      = gx_prod[7:0];
    assign gy      = gy_prod[7:0];

    logic signed [7:0] pose_x_reg, pose_y_reg, gx_reg, gy_reg;
    logic signed [8:0] heading_reg;
    logic signed [8:0] dx_reg, dy_reg;
    logic        [7:0] ax_reg, ay_reg;

    assign dx_w = {gx[7], gx} - {pose_x_reg[7], pose_x_reg};
    assign dy_w = {gy[7], gy} - {pose_y_reg[7], pose_y_reg};

    logic [8:0] adx_w, ady_w;
    assign adx_w = dx_w[8] ? 9'(-dx_w) : 9'(dx_w);
    assign ady_w = dy_w[8] ? 9'(-dy_w) : 9'(dy_w);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gx_reg <= gx;
            gy_reg <= gy;
            dx_reg <= dx_w;
            dy_reg <= dy_w;
            ax_reg <= adx_w[7:0];
            ay_reg <= ady_w[7:0];
        end
    end

    // squares, scaled sum, integer root
    logic [15:0] sqx_reg, sqy_reg;
    logic [31:0] n_reg, r_reg, bit_reg;
    logic [32:0] trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sqx_reg <= {8'd0, ax_reg} * {8'd0, ax_reg};
            sqy_reg <= {8'd0, ay_reg} * {8'd0, ay_reg};
        end
        if (cmd.setup) begin
            n_reg   <= ({16'd0, sqx_reg} + {16'd0, sqy_reg}) * {16'd0, DIST_SCALE};
            r_reg   <= 32'd0;
            bit_reg <= 32'h4000_0000;
        end else if (cmd.step) begin
            if ({1'b0, n_reg} >= trial) begin
                n_reg <= n_reg - trial[31:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // CORDIC, vectoring
    logic signed [27:0] cx_reg, cy_reg, sx, sy;
    logic signed [24:0] cz_reg, atan_w;

    assign sx     = cx_reg >>> cmd.iter;
    assign sy     = cy_reg >>> cmd.iter;
    assign atan_w = $signed({2'b00, ATAN_Q16[cmd.iter]});

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            cx_reg <= $signed({4'd0, ax_reg, 16'd0});
            cy_reg <= $signed({4'd0, ay_reg, 16'd0});
            cz_reg <= 25'sd0;
        end else if (cmd.step) begin
            if (cy_reg > 28'sd0) begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                cz_reg <= cz_reg + atan_w;
            end else begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                cz_reg <= cz_reg - atan_w;
            end
        end
    end

    // bearing
    logic [22:0] a_clamp, a_sel;
    logic [23:0] mag_q16;
    logic [7:0]  deg;

    always_comb begin
        if (cz_reg < 25'sd1) begin
            a_clamp = 23'd1;
        end else if (cz_reg > $signed({2'b00, A_MAX_Q16})) begin
            a_clamp = A_MAX_Q16;
        end else begin
            a_clamp = cz_reg[22:0];
        end
        priority if (ay_reg == 8'd0) begin
            a_sel = 23'd0;
        end else if (ax_reg == 8'd0) begin
            a_sel = DEG90_Q16;
        end else if (ax_reg == ay_reg) begin
            a_sel = DEG45_Q16;
        end else begin
            a_sel = a_clamp;
        end
        mag_q16 = dx_reg[8] ? (DEG180_Q16 - {1'b0, a_sel}) : {1'b0, a_sel};
        deg     = mag_q16[23:16];
    end

    logic signed [8:0] theta_reg;
    logic [32:0]       dist_prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.post1) begin
            if (ax_reg == 8'd0 && ay_reg == 8'd0) begin
                theta_reg <= 9'sd0;
            end else if (dy_reg[8]) begin
                theta_reg <= -$signed({1'b0, deg});
            end else begin
                theta_reg <= $signed({1'b0, deg});
            end
            dist_prod_reg <= r_reg[15:0] * RECIP_27;
        end
    end

    // heading change and spin steps
    logic signed [9:0] dth;
    logic        [9:0] adth;
    logic        [7:0] magh;
    logic        [11:0] dist_q;

    assign dth    = {theta_reg[8], theta_reg} - {heading_reg[8], heading_reg};
    assign adth   = dth[9] ? 10'(-dth) : 10'(dth);
    assign magh   = (adth > 10'd180) ? adth[8:1] : adth[7:0];
    assign dist_q = dist_prod_reg[32:21];

    logic        has_spin_reg, dbl_reg;
    move_kind_t  spin_kind_reg;
    logic [15:0] spin_prod_reg;
    logic [10:0] dist_steps_reg, spin_steps_reg;
    logic [31:0] spin_q;

    assign spin_q = spin_prod_reg * RECIP_90;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_x_reg  <= 8'sd0;
            pose_y_reg  <= 8'sd0;
            heading_reg <= 9'sd0;
        end else if (cmd.post2) begin
            pose_x_reg  <= gx_reg;
            pose_y_reg  <= gy_reg;
            heading_reg <= theta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.post2) begin
            has_spin_reg   <= (dth != 10'sd0);
            dbl_reg        <= (adth > 10'd180);
            spin_kind_reg  <= (dth > 10'sd0) ? MOVE_SPIN_LEFT : MOVE_SPIN_RIGHT;
            spin_prod_reg  <= magh * spra_reg;
            dist_steps_reg <= (dist_q > {1'b0, STEP_MAX}) ? STEP_MAX : dist_q[10:0];
        end
        if (cmd.post3) begin
            spin_steps_reg <= {1'b0, spin_q[31:22]};
        end
    end

    assign status.has_spin = has_spin_reg;
    assign status.dbl      = dbl_reg;

    // result payload, stable while the transaction waits
    always_comb begin
        unique case (cmd.sel)
            SEL_SPIN: begin
                move_kind  = spin_kind_reg;
                step_count = spin_steps_reg;
                move_speed = turn_speed_reg;
                move_accel = turn_accel_reg;
                last_move  = 1'b0;
            end
            SEL_FWD: begin
                move_kind  = MOVE_FORWARD;
                step_count = dist_steps_reg;
                move_speed = drive_speed_reg;
                move_accel = drive_accel_reg;
                last_move  = 1'b1;
            end
            default: begin
                move_kind  = MOVE_FORWARD;
                step_count = dist_steps_reg;
                move_speed = drive_speed_reg;
                move_accel = drive_accel_reg;
                last_move  = 1'b1;
            end
        endcase
    end

endmodule

// File: design/waypoint_turn_and_drive_planner.sv
// Waypoint turn-and-drive planner. Each input transaction carries a goal
// point in feet; the block turns it into inches, forms the offset from the
// stored pose, and returns up to three move transactions: one spin (or two
// equal half spins when the heading change exceeds 180 degrees) followed by
// a forward move flagged with tlast. Bearing comes from a 16-iteration
// vectoring CORDIC and distance from a 16-iteration bit-serial square root,
// both stepped together by one shared counter. The block captures the goal
// when the input is accepted, then steps through square, setup, the 16
// iterations and three post steps before it offers the first result. Each
// further result is offered in the cycle after the sink takes the one
// before, and s_tready returns in the cycle after the forward move leaves.
// Only one item is in flight; s_tready is high while the block is idle.
// Configuration writes must be issued only while the block is idle.
module waypoint_turn_and_drive_planner
    import wtdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    // goal channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] goal_x, [7:4] goal_y
    // move channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] step_count, [20:11] move_speed,
                                   // [30:21] move_accel, [31] zero
    output logic [1:0]  m_tuser,   // [1:0] move_kind
    output logic        m_tlast    // last_move
);

    cmd_t        cmd;
    status_t     status;
    logic [10:0] step_count;
    logic [9:0]  move_speed, move_accel;

    wtdp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    wtdp_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .goal_x     (s_tdata[3:0]),
        .goal_y     (s_tdata[7:4]),
        .cmd        (cmd),
        .status     (status),
        .move_kind  (m_tuser),
        .step_count (step_count),
        .move_speed (move_speed),
        .move_accel (move_accel),
        .last_move  (m_tlast)
    );

    assign m_tdata = {1'b0, move_accel, move_speed, step_count};

endmodule
